/* hdl/fcsp_pkg.sv */
`timescale 1ns / 1ps

package fcsp_pkg;

	// event codes on the action field
	localparam logic [1:0] ACT_TICK        = 2'd0;
	localparam logic [1:0] ACT_START_CLOSE = 2'd1;
	localparam logic [1:0] ACT_VALVE       = 2'd2;
	localparam logic [1:0] ACT_PURGE_COUNT = 2'd3;

	// fan commands
	localparam logic [1:0] FAN_NONE    = 2'd0;
	localparam logic [1:0] FAN_MIN_RUN = 2'd1;
	localparam logic [1:0] FAN_IDLE    = 2'd2;
	localparam logic [1:0] FAN_STOP    = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_VOLTAGE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_VOLTAGE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PURGE_OPEN_TIME   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORCED_PERIOD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORCED_OPEN_TIME  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_PURGE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_THRESHOLD  = 3'd6;

	// configuration reset values
	localparam logic [15:0] RST_START_VOLTAGE    = 16'd3000;
	localparam logic [15:0] RST_CLOSE_VOLTAGE    = 16'd2000;
	localparam logic [15:0] RST_PURGE_OPEN_TIME  = 16'd225;
	localparam logic [31:0] RST_FORCED_PERIOD    = 32'd600000;
	localparam logic [15:0] RST_FORCED_OPEN_TIME = 16'd3000;
	localparam logic [15:0] RST_STARTUP_PURGE    = 16'd3000;
	localparam logic [31:0] RST_CHARGE_THRESHOLD = 32'd10000000;

	// minimum charge added per tick at low stack current
	localparam logic [15:0] MIN_CHARGE_STEP = 16'd100;

	// idle readiness limits
	localparam logic [15:0] IDLE_V_MAX   = 16'd100;
	localparam logic [15:0] IDLE_I_MAX   = 16'd100;
	localparam logic [15:0] IDLE_BI_LT   = 16'd500;
	localparam logic [15:0] BV_GT_IDLE   = 16'd4400;
	localparam logic [15:0] BV_MAX       = 16'd5000;
	localparam logic [15:0] IDLE_T_LT    = 16'd4000;
	localparam logic [7:0]  IDLE_P_MAX   = 8'd2;

	// running readiness limits
	localparam logic [15:0] RUN_V_MIN    = 16'd4500;
	localparam logic [15:0] RUN_V_LT     = 16'd8000;
	localparam logic [15:0] RUN_I_MAX    = 16'd6000;
	localparam logic [15:0] RUN_BI_LT    = 16'd5500;
	localparam logic [15:0] RUN_BV_MIN   = 16'd4400;
	localparam logic [15:0] RUN_T_LT     = 16'd5500;
	localparam logic [15:0] RUN_CT_LT    = 16'd6500;
	localparam logic [7:0]  RUN_P_GT     = 8'd5;
	localparam logic [7:0]  RUN_P_MAX    = 8'd35;

	function automatic logic idle_ok(input logic [15:0] v, input logic [15:0] i,
			input logic [15:0] bi, input logic [15:0] bv, input logic [15:0] t,
			input logic [15:0] ct, input logic [7:0] p);
		return (v <= IDLE_V_MAX) && (i <= IDLE_I_MAX) && (bi < IDLE_BI_LT) &&
			(bv > BV_GT_IDLE) && (bv <= BV_MAX) && (t < IDLE_T_LT) &&
			(ct < IDLE_T_LT) && (p <= IDLE_P_MAX);
	endfunction

	function automatic logic run_ok(input logic [15:0] v, input logic [15:0] i,
			input logic [15:0] bi, input logic [15:0] bv, input logic [15:0] t,
			input logic [15:0] ct, input logic [7:0] p);
		return (v >= RUN_V_MIN) && (v < RUN_V_LT) && (i <= RUN_I_MAX) &&
			(bi < RUN_BI_LT) && (bv >= RUN_BV_MIN) && (bv <= BV_MAX) &&
			(t != 16'd0) && (t < RUN_T_LT) && (ct < RUN_CT_LT) &&
			(p > RUN_P_GT) && (p <= RUN_P_MAX);
	endfunction

endpackage

/* hdl/fuel_cell_start_purge_controller.sv */
`timescale 1ns / 1ps

// Fuel-cell stack start, shutdown and purge-valve sequencer.
// Input channel (in_valid/in_ready): one event beat per item, selected by
// action: 1 ms tick, start/close check, valve control, purge count.
// Output channel (out_valid/out_ready): exactly one result beat per event,
// carrying valve drive, started/purging flags, readiness and fan command.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write only while no event is in flight. Unknown indexes are dropped.
// An accepted event is held in the input register, and its result is then
// loaded into the result register. Throughput: one event per cycle while the
// receiver takes results, set by the single compare and update stage between
// the input and result registers; the controller state updates at the same
// edge the result is registered. When the receiver stalls, the result register
// holds, the input register fills, and in_ready drops until out_ready returns.
// Reset (arst_n low) clears all flags, timers and the charge accumulator,
// loads default configuration values and empties both stages.
module fuel_cell_start_purge_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic [15:0]                       stack_voltage,
	input  logic [15:0]                       stack_current,
	input  logic [15:0]                       battery_current,
	input  logic [15:0]                       battery_voltage,
	input  logic [15:0]                       stack_temp,
	input  logic [15:0]                       case_temp,
	input  logic [7:0]                        tank_pressure,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              valve_open,
	output logic                              stack_started,
	output logic                              startup_purging,
	output logic                              system_ready,
	output logic [1:0]                        fan_command,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data
);

	// configuration
	logic [15:0] start_voltage_q, close_voltage_q, purge_open_time_q;
	logic [15:0] forced_open_time_q, startup_purge_time_q;
	logic [31:0] forced_period_q, charge_threshold_q;

	// controller state
	logic        started_q, startup_q, request_q, valve_q, ready_q;
	logic [15:0] purge_timer_q, startup_timer_q;
	logic [31:0] forced_timer_q, charge_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] v_s1, i_s1, bi_s1, bv_s1, t_s1, ct_s1;
	logic [7:0]  p_s1;

	// result register
	logic        out_valid_q, valve_out_q, started_out_q, startup_out_q, ready_out_q;
	logic [1:0]  fan_out_q;

	logic        take_s1;

	// next-state values
	logic        started_d, startup_d, request_d, valve_d, ready_d;
	logic [15:0] purge_timer_d, startup_timer_d;
	logic [31:0] forced_timer_d, charge_d;
	logic [1:0]  fan_d;

	assign take_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || take_s1;
	assign cfg_ready = 1'b1;

	assign out_valid       = out_valid_q;
	assign valve_open      = valve_out_q;
	assign stack_started   = started_out_q;
	assign startup_purging = startup_out_q;
	assign system_ready    = ready_out_q;
	assign fan_command     = fan_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_voltage_q      <= fcsp_pkg::RST_START_VOLTAGE;
			close_voltage_q      <= fcsp_pkg::RST_CLOSE_VOLTAGE;
			purge_open_time_q    <= fcsp_pkg::RST_PURGE_OPEN_TIME;
			forced_period_q      <= fcsp_pkg::RST_FORCED_PERIOD;
			forced_open_time_q   <= fcsp_pkg::RST_FORCED_OPEN_TIME;
			startup_purge_time_q <= fcsp_pkg::RST_STARTUP_PURGE;
			charge_threshold_q   <= fcsp_pkg::RST_CHARGE_THRESHOLD;
		end else if (cfg_valid) begin
			case (cfg_index)
				fcsp_pkg::REG_START_VOLTAGE:    start_voltage_q      <= cfg_data[15:0];
				fcsp_pkg::REG_CLOSE_VOLTAGE:    close_voltage_q      <= cfg_data[15:0];
				fcsp_pkg::REG_PURGE_OPEN_TIME:  purge_open_time_q    <= cfg_data[15:0];
				fcsp_pkg::REG_FORCED_PERIOD:    forced_period_q      <= cfg_data;
				fcsp_pkg::REG_FORCED_OPEN_TIME: forced_open_time_q   <= cfg_data[15:0];
				fcsp_pkg::REG_STARTUP_PURGE:    startup_purge_time_q <= cfg_data[15:0];
				fcsp_pkg::REG_CHARGE_THRESHOLD: charge_threshold_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			v_s1      <= stack_voltage;
			i_s1      <= stack_current;
			bi_s1     <= battery_current;
			bv_s1     <= battery_voltage;
			t_s1      <= stack_temp;
			ct_s1     <= case_temp;
			p_s1      <= tank_pressure;
		end
	end

	always_comb begin
		logic [15:0] add;
		logic [32:0] sum;
		started_d       = started_q;
		startup_d       = startup_q;
		request_d       = request_q;
		valve_d         = valve_q;
		ready_d         = ready_q;
		purge_timer_d   = purge_timer_q;
		startup_timer_d = startup_timer_q;
		forced_timer_d  = forced_timer_q;
		charge_d        = charge_q;
		fan_d           = fcsp_pkg::FAN_NONE;
		add = (i_s1 <= fcsp_pkg::MIN_CHARGE_STEP) ? fcsp_pkg::MIN_CHARGE_STEP : i_s1;
		sum = {1'b0, charge_q} + {17'd0, add};

		case (action_s1)
			fcsp_pkg::ACT_TICK: begin
				if (purge_timer_q != 16'hFFFF) purge_timer_d = purge_timer_q + 16'd1;
				if (startup_timer_q != 16'hFFFF) startup_timer_d = startup_timer_q + 16'd1;
				if (forced_timer_q != 32'hFFFF_FFFF) forced_timer_d = forced_timer_q + 32'd1;
				charge_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end
			fcsp_pkg::ACT_START_CLOSE: begin
				if (!started_q && !startup_q && (v_s1 > start_voltage_q)) begin
					startup_d = 1'b1;
					fan_d     = fcsp_pkg::FAN_MIN_RUN;
				end
				if (!started_q && !startup_q && (v_s1 < start_voltage_q)) begin
					forced_timer_d = 32'd0;
					request_d      = 1'b0;
					charge_d       = 32'd0;
					valve_d        = 1'b0;
					fan_d          = fcsp_pkg::FAN_IDLE;
				end
				if (started_q && !startup_q && (v_s1 < close_voltage_q)) begin
					started_d = 1'b0;
					valve_d   = 1'b0;
					fan_d     = fcsp_pkg::FAN_STOP;
				end
				// readiness follows the flags as just updated
				if (started_d) begin
					ready_d = fcsp_pkg::run_ok(v_s1, i_s1, bi_s1, bv_s1, t_s1, ct_s1, p_s1);
				end else if (!startup_d) begin
					ready_d = fcsp_pkg::idle_ok(v_s1, i_s1, bi_s1, bv_s1, t_s1, ct_s1, p_s1);
				end
			end
			fcsp_pkg::ACT_VALVE: begin
				if (started_q) begin
					if (request_q && !valve_q) begin
						valve_d       = 1'b1;
						purge_timer_d = 16'd0;
						request_d     = 1'b0;
					end
					if (forced_timer_q > forced_period_q) begin
						if (purge_timer_d > forced_open_time_q && valve_d) begin
							purge_timer_d  = 16'd0;
							forced_timer_d = 32'd0;
							valve_d        = 1'b0;
						end
					end else if (purge_timer_d > purge_open_time_q && valve_d) begin
						purge_timer_d = 16'd0;
						valve_d       = 1'b0;
					end
				end else if (startup_q) begin
					if (!valve_q) begin
						valve_d         = 1'b1;
						startup_timer_d = 16'd0;
					end
					if (startup_timer_d > startup_purge_time_q && valve_d) begin
						startup_timer_d = 16'd0;
						valve_d         = 1'b0;
						startup_d       = 1'b0;
						started_d       = 1'b1;
					end
				end
			end
			fcsp_pkg::ACT_PURGE_COUNT: begin
				if (charge_q > charge_threshold_q && !request_q && !valve_q) begin
					request_d = 1'b1;
					charge_d  = 32'd0;
				end
				if (forced_timer_q > forced_period_q && !request_d && !valve_q) begin
					request_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q       <= 1'b0;
			startup_q       <= 1'b0;
			request_q       <= 1'b0;
			valve_q         <= 1'b0;
			ready_q         <= 1'b0;
			purge_timer_q   <= 16'd0;
			startup_timer_q <= 16'd0;
			forced_timer_q  <= 32'd0;
			charge_q        <= 32'd0;
		end else if (take_s1) begin
			started_q       <= started_d;
			startup_q       <= startup_d;
			request_q       <= request_d;
			valve_q         <= valve_d;
			ready_q         <= ready_d;
			purge_timer_q   <= purge_timer_d;
			startup_timer_q <= startup_timer_d;
			forced_timer_q  <= forced_timer_d;
			charge_q        <= charge_d;
		end
	end

	// result register: load on a processed event, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			valve_out_q   <= valve_d;
			started_out_q <= started_d;
			startup_out_q <= startup_d;
			ready_out_q   <= ready_d;
			fan_out_q     <= fan_d;
		end
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(started_q && startup_q))
		else $error("started and startup purge flags both set");

	a_take_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> out_valid_q)
		else $error("processed event left no result");

	a_purge_timer_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && action_s1 == fcsp_pkg::ACT_TICK && purge_timer_q == 16'hFFFF)
		|=> purge_timer_q == 16'hFFFF)
		else $error("purge timer wrapped");

	a_stop_means_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fan_out_q == fcsp_pkg::FAN_STOP) |-> !started_out_q)
		else $error("fan stop with stack still started");

	a_min_run_means_purging: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fan_out_q == fcsp_pkg::FAN_MIN_RUN) |-> startup_out_q)
		else $error("fan minimum run without startup purge");

endmodule

/* tb/tb_fuel_cell_start_purge_controller.sv */
`timescale 1ns / 1ps

module tb_fuel_cell_start_purge_controller;

	localparam int unsigned TOTAL_ITEMS = 1950;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam logic [fcsp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] v;
		logic [15:0] i;
		logic [15:0] bi;
		logic [15:0] bv;
		logic [15:0] t;
		logic [15:0] ct;
		logic [7:0]  p;
	} fc_event_t;

	typedef struct packed {
		logic       valve;
		logic       started;
		logic       purging;
		logic       ready;
		logic [1:0] fan;
	} fc_status_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	fc_event_t                      drv;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           valve_open;
	logic                           stack_started;
	logic                           startup_purging;
	logic                           system_ready;
	logic [1:0]                     fan_command;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [fcsp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                    cfg_data;

	fuel_cell_start_purge_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(drv.action),
		.stack_voltage(drv.v),
		.stack_current(drv.i),
		.battery_current(drv.bi),
		.battery_voltage(drv.bv),
		.stack_temp(drv.t),
		.case_temp(drv.ct),
		.tank_pressure(drv.p),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.valve_open(valve_open),
		.stack_started(stack_started),
		.startup_purging(startup_purging),
		.system_ready(system_ready),
		.fan_command(fan_command),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// controller image kept in step with accepted beats
	logic        ctl_started, ctl_purging, ctl_request, ctl_valve, ctl_ready;
	logic [15:0] ctl_purge_tmr, ctl_startup_tmr;
	logic [31:0] ctl_forced_tmr, ctl_charge;
	logic [15:0] lim_start_v, lim_close_v, t_purge_open, t_forced_open, t_startup_purge;
	logic [31:0] t_forced_period, lim_charge;

	fc_status_t  expected_status_q[$];
	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	bit          gaps_on = 1'b0;
	bit          stall_enable = 1'b0;
	bit          hold_active = 1'b0;
	bit          ready_state = 1'b1;
	int unsigned ready_run = 0;
	event        hold_start;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	always begin
		@(hold_start);
		hold_active = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	// receiver stall pattern: alternating runs of ready and stall
	always @(negedge clk) begin
		if (ready_run == 0) begin
			ready_state = !ready_state;
			ready_run = ready_state ? $urandom_range(1, 12) : $urandom_range(1, 5);
		end
		ready_run--;
		out_ready <= hold_active ? 1'b0 : (stall_enable ? ready_state : 1'b1);
	end

	task automatic check_field(input string name, input logic [1:0] exp_v, input logic [1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		fc_status_t exp_st;
		if (arst_n && out_valid && out_ready) begin
			if (expected_status_q.size() == 0) begin
				$display("%0t: result beat with no expectation waiting", $time);
				error_count++;
			end else begin
				exp_st = expected_status_q.pop_front();
				check_field("valve_open", {1'b0, exp_st.valve}, {1'b0, valve_open});
				check_field("stack_started", {1'b0, exp_st.started}, {1'b0, stack_started});
				check_field("startup_purging", {1'b0, exp_st.purging},
					{1'b0, startup_purging});
				check_field("system_ready", {1'b0, exp_st.ready}, {1'b0, system_ready});
				check_field("fan_command", exp_st.fan, fan_command);
			end
		end
	end

	task automatic reset_controller_image();
		lim_start_v = 16'd3000;
		lim_close_v = 16'd2000;
		t_purge_open = 16'd225;
		t_forced_period = 32'd600000;
		t_forced_open = 16'd3000;
		t_startup_purge = 16'd3000;
		lim_charge = 32'd10000000;
		ctl_started = 1'b0;
		ctl_purging = 1'b0;
		ctl_request = 1'b0;
		ctl_valve = 1'b0;
		ctl_ready = 1'b0;
		ctl_purge_tmr = '0;
		ctl_startup_tmr = '0;
		ctl_forced_tmr = '0;
		ctl_charge = '0;
	endtask

	function automatic logic stack_idle_ok(input fc_event_t ev);
		return ev.v <= 16'd100 && ev.i <= 16'd100 && ev.bi < 16'd500 && ev.bv > 16'd4400 &&
			ev.bv <= 16'd5000 && ev.t < 16'd4000 && ev.ct < 16'd4000 && ev.p <= 8'd2;
	endfunction

	function automatic logic stack_run_ok(input fc_event_t ev);
		return ev.v >= 16'd4500 && ev.v < 16'd8000 && ev.i <= 16'd6000 && ev.bi < 16'd5500 &&
			ev.bv >= 16'd4400 && ev.bv <= 16'd5000 && ev.t > 16'd0 && ev.t < 16'd5500 &&
			ev.ct < 16'd6500 && ev.p > 8'd5 && ev.p <= 8'd35;
	endfunction

	task automatic predict_status(input fc_event_t ev, output fc_status_t st);
		logic [1:0]  fan;
		logic [15:0] add;
		logic [32:0] sum;
		fan = fcsp_pkg::FAN_NONE;
		case (ev.action)
			fcsp_pkg::ACT_TICK: begin
				add = (ev.i <= 16'd100) ? 16'd100 : ev.i;
				if (ctl_purge_tmr != 16'hFFFF) ctl_purge_tmr++;
				if (ctl_startup_tmr != 16'hFFFF) ctl_startup_tmr++;
				if (ctl_forced_tmr != 32'hFFFF_FFFF) ctl_forced_tmr++;
				sum = {1'b0, ctl_charge} + {17'd0, add};
				ctl_charge = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end
			fcsp_pkg::ACT_START_CLOSE: begin
				if (!ctl_started && ev.v > lim_start_v && !ctl_purging) begin
					ctl_purging = 1'b1;
					fan = fcsp_pkg::FAN_MIN_RUN;
				end
				if (!ctl_started && ev.v < lim_start_v && !ctl_purging) begin
					ctl_forced_tmr = '0;
					ctl_request = 1'b0;
					ctl_charge = '0;
					ctl_valve = 1'b0;
					fan = fcsp_pkg::FAN_IDLE;
				end
				if (ctl_started && ev.v < lim_close_v && !ctl_purging) begin
					ctl_started = 1'b0;
					ctl_valve = 1'b0;
					fan = fcsp_pkg::FAN_STOP;
				end
				if (ctl_started)
					ctl_ready = stack_run_ok(ev);
				else if (!ctl_purging)
					ctl_ready = stack_idle_ok(ev);
			end
			fcsp_pkg::ACT_VALVE: begin
				if (ctl_started) begin
					if (ctl_request && !ctl_valve) begin
						ctl_valve = 1'b1;
						ctl_purge_tmr = '0;
						ctl_request = 1'b0;
					end
					if (ctl_forced_tmr > t_forced_period) begin
						if (ctl_purge_tmr > t_forced_open && ctl_valve) begin
							ctl_purge_tmr = '0;
							ctl_forced_tmr = '0;
							ctl_valve = 1'b0;
						end
					end else if (ctl_purge_tmr > t_purge_open && ctl_valve) begin
						ctl_purge_tmr = '0;
						ctl_valve = 1'b0;
					end
				end else if (ctl_purging) begin
					if (!ctl_valve) begin
						ctl_valve = 1'b1;
						ctl_startup_tmr = '0;
					end
					if (ctl_startup_tmr > t_startup_purge && ctl_valve) begin
						ctl_startup_tmr = '0;
						ctl_valve = 1'b0;
						ctl_purging = 1'b0;
						ctl_started = 1'b1;
					end
				end
			end
			default: begin
				if (ctl_charge > lim_charge && !ctl_request && !ctl_valve) begin
					ctl_request = 1'b1;
					ctl_charge = '0;
				end
				if (ctl_forced_tmr > t_forced_period && !ctl_request && !ctl_valve)
					ctl_request = 1'b1;
			end
		endcase
		st.valve = ctl_valve;
		st.started = ctl_started;
		st.purging = ctl_purging;
		st.ready = ctl_ready;
		st.fan = fan;
	endtask

	task automatic send_item(input fc_event_t ev);
		fc_status_t st;
		if (gaps_on && burst_left == 0) begin
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left != 0)
			burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		drv <= ev;
		do @(posedge clk); while (!in_ready);
		predict_status(ev, st);
		expected_status_q.push_back(st);
		items_sent++;
	endtask

	task automatic write_reg(input logic [fcsp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fcsp_pkg::REG_START_VOLTAGE: lim_start_v = data[15:0];
			fcsp_pkg::REG_CLOSE_VOLTAGE: lim_close_v = data[15:0];
			fcsp_pkg::REG_PURGE_OPEN_TIME: t_purge_open = data[15:0];
			fcsp_pkg::REG_FORCED_PERIOD: t_forced_period = data;
			fcsp_pkg::REG_FORCED_OPEN_TIME: t_forced_open = data[15:0];
			fcsp_pkg::REG_STARTUP_PURGE: t_startup_purge = data[15:0];
			fcsp_pkg::REG_CHARGE_THRESHOLD: lim_charge = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold input until every result is back, then let the pipe settle
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic fc_event_t make_event(input logic [1:0] action, input logic [15:0] v,
			input logic [15:0] i, input logic [15:0] bi, input logic [15:0] bv,
			input logic [15:0] t, input logic [15:0] ct, input logic [7:0] p);
		fc_event_t ev;
		ev.action = action;
		ev.v = v;
		ev.i = i;
		ev.bi = bi;
		ev.bv = bv;
		ev.t = t;
		ev.ct = ct;
		ev.p = p;
		return ev;
	endfunction

	function automatic logic [15:0] near16(input logic [15:0] b);
		logic [15:0] off;
		off = 16'($urandom_range(0, 4));
		return b + off - 16'd2;
	endfunction

	function automatic logic [15:0] above(input logic [15:0] b);
		if (b == 16'hFFFF)
			return b;
		return 16'($urandom_range(32'hFFFF, int'(b) + 1));
	endfunction

	function automatic logic [15:0] below(input logic [15:0] b);
		if (b == 16'd0)
			return b;
		return 16'($urandom_range(int'(b) - 1, 0));
	endfunction

	// healthy idle or running readings, sometimes with one field pushed to a limit or all fields random
	function automatic fc_event_t gen_fields(input bit running);
		fc_event_t ev;
		logic [7:0] pb;
		ev.action = fcsp_pkg::ACT_TICK;
		if (running) begin
			ev.v = 16'($urandom_range(4500, 7999));
			ev.i = 16'($urandom_range(0, 6000));
			ev.bi = 16'($urandom_range(0, 5499));
			ev.bv = 16'($urandom_range(4400, 5000));
			ev.t = 16'($urandom_range(1, 5499));
			ev.ct = 16'($urandom_range(0, 6499));
			ev.p = 8'($urandom_range(6, 35));
		end else begin
			ev.v = 16'($urandom_range(0, 100));
			ev.i = 16'($urandom_range(0, 100));
			ev.bi = 16'($urandom_range(0, 499));
			ev.bv = 16'($urandom_range(4401, 5000));
			ev.t = 16'($urandom_range(0, 3999));
			ev.ct = 16'($urandom_range(0, 3999));
			ev.p = 8'($urandom_range(0, 2));
		end
		if ($urandom_range(0, 9) < 4) begin
			case ($urandom_range(0, 7))
				0: ev.v = near16($urandom_range(0, 2) == 0 ? 16'd100 :
					($urandom_range(0, 1) ? 16'd4500 : 16'd8000));
				1: ev.i = near16($urandom_range(0, 1) ? 16'd100 : 16'd6000);
				2: ev.bi = near16($urandom_range(0, 1) ? 16'd500 : 16'd5500);
				3: ev.bv = near16($urandom_range(0, 1) ? 16'd4400 : 16'd5000);
				4: ev.t = near16($urandom_range(0, 2) == 0 ? 16'd0 :
					($urandom_range(0, 1) ? 16'd4000 : 16'd5500));
				5: ev.ct = near16($urandom_range(0, 1) ? 16'd4000 : 16'd6500);
				6: begin
					pb = $urandom_range(0, 2) == 0 ? 8'd2 : ($urandom_range(0, 1) ? 8'd5 : 8'd35);
					ev.p = pb + 8'($urandom_range(0, 4)) - 8'd2;
				end
				default: begin
					ev.v = 16'($urandom);
					ev.i = 16'($urandom);
					ev.bi = 16'($urandom);
					ev.bv = 16'($urandom);
					ev.t = 16'($urandom);
					ev.ct = 16'($urandom);
					ev.p = 8'($urandom);
				end
			endcase
		end
		return ev;
	endfunction

	// mostly events that fit the current phase, some noise
	function automatic fc_event_t next_event();
		fc_event_t ev;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			ev.action = 2'($urandom);
			ev.v = 16'($urandom);
			ev.i = 16'($urandom);
			ev.bi = 16'($urandom);
			ev.bv = 16'($urandom);
			ev.t = 16'($urandom);
			ev.ct = 16'($urandom);
			ev.p = 8'($urandom);
			return ev;
		end
		r = $urandom_range(0, 99);
		if (!ctl_started && !ctl_purging) begin
			if (r < 35) begin
				ev = gen_fields(1'b0);
				ev.action = fcsp_pkg::ACT_START_CLOSE;
			end else if (r < 60) begin
				ev = gen_fields(1'b1);
				ev.action = fcsp_pkg::ACT_START_CLOSE;
				ev.v = above(lim_start_v);
			end else if (r < 85) begin
				ev = gen_fields(1'b0);
				ev.action = fcsp_pkg::ACT_TICK;
			end else begin
				ev = gen_fields(1'b0);
				ev.action = $urandom_range(0, 1) ? fcsp_pkg::ACT_VALVE :
					fcsp_pkg::ACT_PURGE_COUNT;
			end
		end else if (ctl_purging) begin
			ev = gen_fields(1'b1);
			if (r < 45)
				ev.action = fcsp_pkg::ACT_VALVE;
			else if (r < 90)
				ev.action = fcsp_pkg::ACT_TICK;
			else
				ev.action = fcsp_pkg::ACT_START_CLOSE;
		end else begin
			ev = gen_fields(1'b1);
			if (r < 35) begin
				ev.action = fcsp_pkg::ACT_TICK;
				if ($urandom_range(0, 1))
					ev.i = 16'($urandom);
			end else if (r < 60) begin
				ev.action = fcsp_pkg::ACT_VALVE;
			end else if (r < 80) begin
				ev.action = fcsp_pkg::ACT_PURGE_COUNT;
			end else if (r < 95) begin
				ev.action = fcsp_pkg::ACT_START_CLOSE;
			end else begin
				ev.action = fcsp_pkg::ACT_START_CLOSE;
				ev.v = below(lim_close_v);
			end
		end
		return ev;
	endfunction

	function automatic logic [31:0] pick_reg(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] top);
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return top;
			2: return $urandom;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	task automatic test_idle_checks();
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'd3000, 16'd0, 16'd0, 16'd4800,
			16'd2000, 16'd2000, 8'd0));
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'd0, 16'd100, 16'd499, 16'd5000,
			16'd3999, 16'd3999, 8'd2));
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'd100, 16'd101, 16'd0, 16'd4400,
			16'd0, 16'd0, 8'd3));
		send_item(make_event(fcsp_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 8'hFF));
		send_item(make_event(fcsp_pkg::ACT_PURGE_COUNT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 8'd0));
		send_item(make_event(fcsp_pkg::ACT_VALVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
	endtask

	task automatic test_startup_purge();
		wait_drained();
		// upper data bits must be dropped, unknown index ignored
		write_reg(fcsp_pkg::REG_STARTUP_PURGE, 32'h0001_0001);
		write_reg(REG_UNUSED, 32'h1234_5678);
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 8'hFF));
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'd0, 16'd0, 16'd0, 16'd4500, 16'd0,
			16'd0, 8'd0));
		send_item(make_event(fcsp_pkg::ACT_VALVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_TICK, 16'd0, 16'd50, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_VALVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_TICK, 16'd0, 16'd50, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_VALVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
	endtask

	task automatic test_running_purge();
		wait_drained();
		write_reg(fcsp_pkg::REG_CHARGE_THRESHOLD, 32'd0);
		write_reg(fcsp_pkg::REG_PURGE_OPEN_TIME, 32'd0);
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'd4500, 16'd6000, 16'd5499, 16'd4400,
			16'd1, 16'd6499, 8'd6));
		send_item(make_event(fcsp_pkg::ACT_TICK, 16'd0, 16'd6000, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_PURGE_COUNT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 8'd0));
		send_item(make_event(fcsp_pkg::ACT_VALVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_VALVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
	endtask

	task automatic test_forced_purge_and_shutdown();
		wait_drained();
		write_reg(fcsp_pkg::REG_FORCED_PERIOD, 32'd0);
		write_reg(fcsp_pkg::REG_FORCED_OPEN_TIME, 32'hFFFF);
		write_reg(fcsp_pkg::REG_CLOSE_VOLTAGE, 32'hFFFF);
		write_reg(fcsp_pkg::REG_START_VOLTAGE, 32'hFFFF);
		send_item(make_event(fcsp_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_PURGE_COUNT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 8'd0));
		send_item(make_event(fcsp_pkg::ACT_VALVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			8'd0));
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'd7999, 16'd0, 16'd5499, 16'd5000,
			16'd5499, 16'd0, 8'd35));
		wait_drained();
		write_reg(fcsp_pkg::REG_FORCED_PERIOD, 32'hFFFF_FFFF);
		write_reg(fcsp_pkg::REG_CHARGE_THRESHOLD, 32'hFFFF_FFFF);
		write_reg(fcsp_pkg::REG_START_VOLTAGE, 32'd0);
		write_reg(fcsp_pkg::REG_FORCED_OPEN_TIME, 32'd0);
		write_reg(fcsp_pkg::REG_CLOSE_VOLTAGE, 32'd0);
		send_item(make_event(fcsp_pkg::ACT_START_CLOSE, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 8'd0));
	endtask

	task automatic test_input_stall();
		wait_drained();
		gaps_on = 1'b0;
		stall_enable = 1'b0;
		-> hold_start;
		repeat (30) send_item(next_event());
		wait_drained();
	endtask

	task automatic test_random_sessions();
		int unsigned n;
		while (items_sent < TOTAL_ITEMS) begin
			wait_drained();
			write_reg(fcsp_pkg::REG_START_VOLTAGE, pick_reg(1000, 6000, 32'hFFFF));
			write_reg(fcsp_pkg::REG_CLOSE_VOLTAGE, pick_reg(500, 4000, 32'hFFFF));
			write_reg(fcsp_pkg::REG_PURGE_OPEN_TIME, pick_reg(0, 12, 32'hFFFF));
			write_reg(fcsp_pkg::REG_FORCED_PERIOD, pick_reg(0, 80, 32'hFFFF_FFFF));
			write_reg(fcsp_pkg::REG_FORCED_OPEN_TIME, pick_reg(0, 12, 32'hFFFF));
			write_reg(fcsp_pkg::REG_STARTUP_PURGE, pick_reg(0, 15, 32'hFFFF));
			write_reg(fcsp_pkg::REG_CHARGE_THRESHOLD, pick_reg(0, 40000, 32'hFFFF_FFFF));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, $urandom);
			gaps_on = $urandom_range(0, 3) != 0;
			stall_enable = $urandom_range(0, 3) != 0;
			n = $urandom_range(80, 200);
			if (n > TOTAL_ITEMS - items_sent)
				n = TOTAL_ITEMS - items_sent;
			repeat (n) send_item(next_event());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		drv = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_controller_image();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		stall_enable = 1'b1;
		test_idle_checks();
		test_startup_purge();
		gaps_on = 1'b1;
		test_running_purge();
		test_forced_purge_and_shutdown();
		test_input_stall();
		test_random_sessions();

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
